// ===== rtl/aeg_pkg.sv =====
package aeg_pkg;

    localparam int BAND_LOW   = 98;
    localparam int BAND_HIGH  = 102;
    localparam int PCT_BASE   = 100;
    localparam int NUDGE_PCT  = 105;
    localparam int DAMP_DIV   = 3;
    localparam int ACT_AFTER  = 4;
    localparam int DIV_W      = 16;
    localparam int LOG_SQUARES = 16;

    // Reciprocal constants: x/3 = (x*DAMP_RECIP) >> DAMP_SHIFT for x below 2^16, and
    // x/100 = (x*PCT_RECIP) >> PCT_SHIFT for any 32-bit x.
    localparam logic [15:0] DAMP_RECIP = 16'd43691;
    localparam int          DAMP_SHIFT = 17;
    localparam logic [31:0] PCT_RECIP  = 32'd1374389535;
    localparam int          PCT_SHIFT  = 37;

    localparam logic [2:0] CFG_ENABLE    = 3'd0;
    localparam logic [2:0] CFG_TARGET    = 3'd1;
    localparam logic [2:0] CFG_GAIN_MIN  = 3'd2;
    localparam logic [2:0] CFG_GAIN_MAX  = 3'd3;
    localparam logic [2:0] CFG_EXP_MIN   = 3'd4;
    localparam logic [2:0] CFG_EXP_MAX   = 3'd5;
    localparam logic [2:0] CFG_STEPS     = 3'd6;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_GAIN = 2'd1,
        ACT_EXP  = 2'd2
    } action_t;

    typedef struct packed {
        logic        enable;
        logic [7:0]  target_brightness;
        logic [15:0] gain_min;
        logic [15:0] gain_max;
        logic [23:0] exposure_min;
        logic [23:0] exposure_max;
        logic [7:0]  gain_steps_per_doubling;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV1,
        S_DIV1W,
        S_DAMP,
        S_LOGD,
        S_LOGDW,
        S_LOGC,
        S_LOGCW,
        S_MUL,
        S_CLIP,
        S_DEC,
        S_PCT,
        S_PUT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ
    } log_state_t;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        logic     cap_dist;
        logic     cap_dd;
        logic     log_start;
        logic     log_ref;
        logic     cap_logd;
        logic     cap_logc;
        logic     mul_en;
        logic     clip_en;
        logic     dec_en;
        logic     pct_en;
        logic     load_out;
        logic     out_zero;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic log_busy;
    } sts_t;

endpackage

// ===== rtl/aeg_in_if.sv =====
interface aeg_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  brightness;
    logic [15:0] current_gain;
    logic [23:0] current_exposure;

    modport source (output valid, output brightness, output current_gain,
                    output current_exposure, input ready);
    modport sink (input valid, input brightness, input current_gain,
                  input current_exposure, output ready);
endinterface

// ===== rtl/aeg_out_if.sv =====
interface aeg_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [23:0] new_setting;

    modport source (output valid, output action, output new_setting, input ready);
    modport sink (input valid, input action, input new_setting, output ready);
endinterface

// ===== rtl/aeg_div.sv =====
module aeg_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [aeg_pkg::DIV_W-1:0]  dividend,
    input  logic [7:0]                 divisor,
    output logic                       busy,
    output logic [aeg_pkg::DIV_W-1:0]  quotient
);

    logic                      busy_reg, busy_next;
    logic [4:0]                cnt_reg, cnt_next;
    logic [aeg_pkg::DIV_W-1:0] q_reg, q_next;
    logic [7:0]                r_reg, r_next;
    logic [7:0]                dvs_reg;
    logic [8:0]                rs;
    logic [8:0]                diff;

    // Restoring division, one quotient bit per cycle.
    always_comb
    begin
        rs   = {r_reg, q_reg[aeg_pkg::DIV_W-1]};
        diff = rs - {1'b0, dvs_reg};
        if (rs >= {1'b0, dvs_reg})
        begin
            r_next = diff[7:0];
            q_next = {q_reg[aeg_pkg::DIV_W-2:0], 1'b1};
        end
        else
        begin
            r_next = rs[7:0];
            q_next = {q_reg[aeg_pkg::DIV_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(aeg_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            r_reg   <= 8'd0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/aeg_log.sv =====
module aeg_log (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [13:0] x,
    output logic        busy,
    output logic [20:0] result
);

    aeg_pkg::log_state_t state_reg, state_next;
    logic [31:0] m_reg;
    logic [4:0]  n_reg;
    logic [15:0] frac_reg;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] sq;
    logic [32:0] t;
    logic [31:0] m_sq;

    // The mantissa is held in Q1.31; each square yields one fraction bit.
    always_comb
    begin
        sq   = m_reg * m_reg;
        t    = sq[63:31];
        m_sq = t[32] ? t[32:1] : t[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aeg_pkg::LG_IDLE:
            begin
                if (start)
                begin
                    state_next = aeg_pkg::LG_NORM;
                end
            end
            aeg_pkg::LG_NORM:
            begin
                if (m_reg[31])
                begin
                    state_next = aeg_pkg::LG_SQ;
                end
            end
            aeg_pkg::LG_SQ:
            begin
                if (cnt_reg == 4'(aeg_pkg::LOG_SQUARES - 1))
                begin
                    state_next = aeg_pkg::LG_IDLE;
                end
            end
            default:
            begin
                state_next = aeg_pkg::LG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == aeg_pkg::LG_SQ)
        begin
            cnt_next = cnt_reg + 4'd1;
        end
        else if (state_reg == aeg_pkg::LG_NORM)
        begin
            cnt_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aeg_pkg::LG_IDLE;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == aeg_pkg::LG_IDLE && start)
        begin
            m_reg    <= 32'(x);
            n_reg    <= 5'd31;
            frac_reg <= 16'd0;
        end
        else if (state_reg == aeg_pkg::LG_NORM && !m_reg[31])
        begin
            m_reg <= {m_reg[30:0], 1'b0};
            n_reg <= n_reg - 5'd1;
        end
        else if (state_reg == aeg_pkg::LG_SQ)
        begin
            m_reg    <= m_sq;
            frac_reg <= {frac_reg[14:0], t[32]};
        end
    end

    assign busy   = (state_reg != aeg_pkg::LG_IDLE);
    assign result = {n_reg, frac_reg};

endmodule

// ===== rtl/aeg_dp.sv =====
module aeg_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  aeg_pkg::cfg_t cfg,
    input  aeg_pkg::cmd_t cmd,
    input  logic [7:0]    brightness,
    input  logic [15:0]   current_gain,
    input  logic [23:0]   current_exposure,
    output aeg_pkg::sts_t sts,
    output logic [1:0]    action,
    output logic [23:0]   new_setting
);

    logic [7:0]  br_reg;
    logic [15:0] g_reg;
    logic [23:0] e_reg;
    logic [14:0] dist_reg;
    logic [13:0] dd_reg;
    logic [20:0] logd_reg, logc_reg;

    logic [30:0] e100_reg, emin100_reg, emax100_reg, e105_reg;
    logic [37:0] edd_reg;
    logic signed [30:0] prod_reg;

    logic signed [33:0] ng_reg;
    logic [37:0] ne_reg;
    logic [30:0] nn_reg;

    aeg_pkg::action_t act_reg;
    logic        need_div_reg;
    logic [15:0] gval_reg;
    logic [30:0] dsrc_reg;
    logic [60:0] pct_reg;

    logic [1:0]  action_reg;
    logic [23:0] setting_reg;

    logic [aeg_pkg::DIV_W-1:0] div_dividend;
    logic [7:0]  div_divisor;
    logic        div_busy;
    logic [aeg_pkg::DIV_W-1:0] div_quo;
    logic [31:0] dd_prod;
    logic [13:0] log_x;
    logic        log_busy;
    logic [20:0] log_res;

    logic signed [21:0] lv;
    logic signed [8:0]  stp;
    logic signed [33:0] cur, lo, hi, sum, ng_c;
    logic [37:0] ne_c;
    logic [30:0] nn_c;
    logic        out_band, g_lower, e_move, g_raise;
    aeg_pkg::action_t act_c;
    logic        need_div_c;
    logic [15:0] gval_c;
    logic [30:0] dsrc_c;

    // The serial divider only forms the ratio of target to brightness.
    assign div_dividend = 16'(cfg.target_brightness) * 16'(aeg_pkg::PCT_BASE);
    assign div_divisor  = (br_reg == 8'd0) ? 8'd1 : br_reg;

    aeg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // The damped ratio divides by three through a reciprocal multiply.
    assign dd_prod = (32'(dist_reg) + 32'(2 * aeg_pkg::PCT_BASE)) * 32'(aeg_pkg::DAMP_RECIP);

    // A zero distance takes the special path, so the log input only needs to be nonzero.
    always_comb
    begin
        if (cmd.log_ref)
        begin
            log_x = 14'(aeg_pkg::PCT_BASE);
        end
        else if (dist_reg == 15'd0)
        begin
            log_x = 14'd1;
        end
        else if (dist_reg < 15'(aeg_pkg::PCT_BASE))
        begin
            log_x = dist_reg[13:0];
        end
        else
        begin
            log_x = dd_reg;
        end
    end

    aeg_log u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.log_start),
        .x      (log_x),
        .busy   (log_busy),
        .result (log_res)
    );

    always_comb
    begin
        lv  = $signed({1'b0, logd_reg}) - $signed({1'b0, logc_reg});
        stp = $signed({1'b0, cfg.gain_steps_per_doubling});
        cur = $signed({2'b00, g_reg, 16'd0});
        lo  = $signed({2'b00, cfg.gain_min, 16'd0});
        hi  = $signed({2'b00, cfg.gain_max, 16'd0});
        sum = cur + 34'(prod_reg);

        if (dist_reg == 15'd0 && cfg.gain_steps_per_doubling != 8'd0)
        begin
            ng_c = lo;
        end
        else if (sum < lo)
        begin
            ng_c = lo;
        end
        else if (sum > hi)
        begin
            ng_c = hi;
        end
        else
        begin
            ng_c = sum;
        end

        if (edd_reg < 38'(emin100_reg))
        begin
            ne_c = 38'(emin100_reg);
        end
        else if (edd_reg > 38'(emax100_reg))
        begin
            ne_c = 38'(emax100_reg);
        end
        else
        begin
            ne_c = edd_reg;
        end

        if (e105_reg < emin100_reg)
        begin
            nn_c = emin100_reg;
        end
        else if (e105_reg > emax100_reg)
        begin
            nn_c = emax100_reg;
        end
        else
        begin
            nn_c = e105_reg;
        end
    end

    // Gain is lowered, then exposure moved, then gain raised, else exposure nudged up.
    // A clipped exposure never exceeds the larger limit times 100, so 31 bits hold it.
    always_comb
    begin
        out_band = (dist_reg < 15'(aeg_pkg::BAND_LOW)) || (dist_reg > 15'(aeg_pkg::BAND_HIGH));
        g_lower  = ng_reg < cur;
        e_move   = ne_reg != 38'(e100_reg);
        g_raise  = (ng_reg != cur) && (e_reg >= cfg.exposure_max);

        act_c      = aeg_pkg::ACT_NONE;
        need_div_c = 1'b0;
        gval_c     = 16'd0;
        dsrc_c     = ne_reg[30:0];
        priority if (out_band && g_lower)
        begin
            act_c  = aeg_pkg::ACT_GAIN;
            gval_c = ng_reg[31:16];
        end
        else if (out_band && e_move)
        begin
            act_c      = aeg_pkg::ACT_EXP;
            need_div_c = 1'b1;
        end
        else if (out_band && g_raise)
        begin
            act_c  = aeg_pkg::ACT_GAIN;
            gval_c = ng_reg[31:16];
        end
        else if (g_reg > cfg.gain_min && e_reg < cfg.exposure_max)
        begin
            act_c      = aeg_pkg::ACT_EXP;
            need_div_c = 1'b1;
            dsrc_c     = nn_reg;
        end
        else
        begin
            act_c = aeg_pkg::ACT_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            br_reg <= brightness;
            g_reg  <= current_gain;
            e_reg  <= current_exposure;
        end
        if (cmd.cap_dist)
        begin
            dist_reg <= div_quo[14:0];
        end
        if (cmd.cap_dd)
        begin
            dd_reg <= dd_prod[aeg_pkg::DAMP_SHIFT+13:aeg_pkg::DAMP_SHIFT];
        end
        if (cmd.cap_logd)
        begin
            logd_reg <= log_res;
        end
        if (cmd.cap_logc)
        begin
            logc_reg <= log_res;
        end
        if (cmd.mul_en)
        begin
            e100_reg    <= 31'(e_reg) * 31'(aeg_pkg::PCT_BASE);
            emin100_reg <= 31'(cfg.exposure_min) * 31'(aeg_pkg::PCT_BASE);
            emax100_reg <= 31'(cfg.exposure_max) * 31'(aeg_pkg::PCT_BASE);
            e105_reg    <= 31'(e_reg) * 31'(aeg_pkg::NUDGE_PCT);
            edd_reg     <= 38'(e_reg) * 38'(dd_reg);
            prod_reg    <= 31'(lv) * 31'(stp);
        end
        if (cmd.clip_en)
        begin
            ng_reg <= ng_c;
            ne_reg <= ne_c;
            nn_reg <= nn_c;
        end
        if (cmd.dec_en)
        begin
            act_reg  <= act_c;
            gval_reg <= gval_c;
            dsrc_reg <= dsrc_c;
        end
        if (cmd.pct_en)
        begin
            pct_reg <= 61'(dsrc_reg) * 61'(aeg_pkg::PCT_RECIP);
        end
        if (cmd.load_out)
        begin
            if (cmd.out_zero)
            begin
                action_reg  <= aeg_pkg::ACT_NONE;
                setting_reg <= 24'd0;
            end
            else
            begin
                action_reg  <= act_reg;
                setting_reg <= need_div_reg
                               ? pct_reg[aeg_pkg::PCT_SHIFT+23:aeg_pkg::PCT_SHIFT]
                               : 24'(gval_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_div_reg <= 1'b0;
        end
        else if (cmd.dec_en)
        begin
            need_div_reg <= need_div_c;
        end
    end

    assign sts.div_busy = div_busy;
    assign sts.log_busy = log_busy;
    assign action       = action_reg;
    assign new_setting  = setting_reg;

endmodule

// ===== rtl/aeg_ctrl.sv =====
module aeg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enable,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  aeg_pkg::sts_t sts,
    output aeg_pkg::cmd_t cmd
);

    aeg_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0] fc_reg, fc_next;
    logic       acting_reg, acting_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       acting_now;

    assign in_ready   = (state_reg == aeg_pkg::S_IDLE);
    assign accept     = in_valid && in_ready;
    assign acting_now = enable && (fc_reg >= 3'(aeg_pkg::ACT_AFTER));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aeg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = acting_now ? aeg_pkg::S_DIV1 : aeg_pkg::S_PUT;
                end
            end
            aeg_pkg::S_DIV1:   state_next = aeg_pkg::S_DIV1W;
            aeg_pkg::S_DIV1W:
            begin
                if (!sts.div_busy)
                begin
                    state_next = aeg_pkg::S_DAMP;
                end
            end
            aeg_pkg::S_DAMP:   state_next = aeg_pkg::S_LOGD;
            aeg_pkg::S_LOGD:   state_next = aeg_pkg::S_LOGDW;
            aeg_pkg::S_LOGDW:
            begin
                if (!sts.log_busy)
                begin
                    state_next = aeg_pkg::S_LOGC;
                end
            end
            aeg_pkg::S_LOGC:   state_next = aeg_pkg::S_LOGCW;
            aeg_pkg::S_LOGCW:
            begin
                if (!sts.log_busy)
                begin
                    state_next = aeg_pkg::S_MUL;
                end
            end
            aeg_pkg::S_MUL:    state_next = aeg_pkg::S_CLIP;
            aeg_pkg::S_CLIP:   state_next = aeg_pkg::S_DEC;
            aeg_pkg::S_DEC:    state_next = aeg_pkg::S_PCT;
            aeg_pkg::S_PCT:    state_next = aeg_pkg::S_PUT;
            aeg_pkg::S_PUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = aeg_pkg::S_IDLE;
                end
            end
            default:           state_next = aeg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.out_zero = !acting_reg;
        unique case (state_reg)
            aeg_pkg::S_IDLE:   cmd.load_in = accept;
            aeg_pkg::S_DIV1:   cmd.div_start = 1'b1;
            aeg_pkg::S_DIV1W:  cmd.cap_dist = !sts.div_busy;
            aeg_pkg::S_DAMP:   cmd.cap_dd = 1'b1;
            aeg_pkg::S_LOGD:   cmd.log_start = 1'b1;
            aeg_pkg::S_LOGDW:  cmd.cap_logd = !sts.log_busy;
            aeg_pkg::S_LOGC:
            begin
                cmd.log_start = 1'b1;
                cmd.log_ref   = 1'b1;
            end
            aeg_pkg::S_LOGCW:  cmd.cap_logc = !sts.log_busy;
            aeg_pkg::S_MUL:    cmd.mul_en = 1'b1;
            aeg_pkg::S_CLIP:   cmd.clip_en = 1'b1;
            aeg_pkg::S_DEC:    cmd.dec_en = 1'b1;
            aeg_pkg::S_PCT:    cmd.pct_en = 1'b1;
            aeg_pkg::S_PUT:    cmd.load_out = !out_valid_reg || out_ready;
            default:           cmd.load_in = 1'b0;
        endcase
    end

    always_comb
    begin
        fc_next     = fc_reg;
        acting_next = acting_reg;
        if (accept)
        begin
            acting_next = acting_now;
            if (enable)
            begin
                fc_next = acting_now ? 3'd1 : fc_reg + 3'd1;
            end
        end

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aeg_pkg::S_IDLE;
            fc_reg        <= 3'd0;
            acting_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            acting_reg    <= acting_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= 3'(aeg_pkg::ACT_AFTER))
        else $error("frame counter beyond acting point");

    a_act_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && acting_now |=> state_reg == aeg_pkg::S_DIV1)
        else $error("acting word did not start the divide");

    a_put_only: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> state_reg == aeg_pkg::S_PUT && (!out_valid_reg || out_ready))
        else $error("result loaded over a pending word");

    a_idle_skip: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !acting_now |=> state_reg == aeg_pkg::S_PUT && !acting_reg)
        else $error("non-acting word took the compute path");

endmodule

// ===== rtl/auto_exposure_gain_controller.sv =====
// A disabled or non-acting word goes from acceptance straight to the output load state.
// An acting word runs the serial divide by the brightness, damping, the two log2 runs
// (normalize plus 16 squarings), then multiply, clip, decision, scaling by 1/100 and
// the output load.
// The block takes one word at a time; a result not taken holds the next word. Reset
// (rst_n, asynchronous, active low) restores the register defaults, clears the frame
// counter and empties the output register.
module auto_exposure_gain_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    aeg_in_if.sink      frame,
    aeg_out_if.source   result
);

    // Configuration registers. Writes must happen only while the block is idle; the block
    // does not enforce this. The datapath reads them directly without any shadow copy.
    aeg_pkg::cfg_t cfg_reg, cfg_next;
    aeg_pkg::cmd_t cmd;
    aeg_pkg::sts_t sts;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                aeg_pkg::CFG_ENABLE:   cfg_next.enable = cfg_data[0];
                aeg_pkg::CFG_TARGET:   cfg_next.target_brightness = cfg_data[7:0];
                aeg_pkg::CFG_GAIN_MIN: cfg_next.gain_min = cfg_data[15:0];
                aeg_pkg::CFG_GAIN_MAX: cfg_next.gain_max = cfg_data[15:0];
                aeg_pkg::CFG_EXP_MIN:  cfg_next.exposure_min = cfg_data;
                aeg_pkg::CFG_EXP_MAX:  cfg_next.exposure_max = cfg_data;
                aeg_pkg::CFG_STEPS:    cfg_next.gain_steps_per_doubling = cfg_data[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable                  <= 1'b1;
            cfg_reg.target_brightness       <= 8'd128;
            cfg_reg.gain_min                <= 16'd0;
            cfg_reg.gain_max                <= 16'd1023;
            cfg_reg.exposure_min            <= 24'd1;
            cfg_reg.exposure_max            <= 24'd33333;
            cfg_reg.gain_steps_per_doubling <= 8'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller sequences the word: it counts frames, decides whether this
    // word acts, and steps the datapath through divide, damping, log, multiply, clip,
    // decision and scaling phases. The result waits in an output register of its own.
    aeg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (cfg_reg.enable),
        .in_valid  (frame.valid),
        .in_ready  (frame.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the serial divider, the log2 unit and the gain and
    // exposure arithmetic, all in fixed point.
    aeg_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .cmd              (cmd),
        .brightness       (frame.brightness),
        .current_gain     (frame.current_gain),
        .current_exposure (frame.current_exposure),
        .sts              (sts),
        .action           (result.action),
        .new_setting      (result.new_setting)
    );

endmodule
